// File: src/mxs_pkg.sv
// Shared types and constants for the max stack.
// The cell (mxs_cell) and the top level (max_stack_top) both import this package.
`default_nettype none
package mxs_pkg;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOP      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK_MAX = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_MAX  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_FIND,
        CELL_REMOVE,
        CELL_RELAX
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    max_ref;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: src/max_stack_top.sv
// Max stack top level: a row of DEPTH cells with the control sequencer and output register.
// An accepted request enters the execute state, where its result is registered once the
// output register is free. Push, pop, top and peek max end there; pop max then runs a remove
// step and, unless the top entry was removed, a repair wave of the running maximum that moves
// one cell per cycle toward the top. One request is in progress at a time.
// Reset empties the stack and the output register; no clearing pass is needed.
`default_nettype none
module max_stack_top #(
    parameter int DEPTH = mxs_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mxs_pkg::KIND_W-1:0]    kind,
    input  wire logic signed [mxs_pkg::DATA_W-1:0] push_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [mxs_pkg::DATA_W-1:0]  result_value,
    output logic [mxs_pkg::STATUS_W-1:0]       status
);
    import mxs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_REMOVE = 2'd2;
    localparam logic [1:0] ST_WAVE   = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [KIND_W-1:0]   kind_reg;
    data_t               push_value_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    data_t               result_reg;
    data_t               result_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    cell_ctrl_t ctrl;
    data_t      push_max;
    logic       out_free;

    data_t value_w   [DEPTH];
    data_t max_w     [DEPTH];
    logic  take_w    [DEPTH];
    logic  settled_w [DEPTH];
    logic  found_w   [DEPTH];

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign push_max = ((count_reg == '0) || (push_value_reg > max_w[0]))
                      ? push_value_reg : max_w[0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        status_next    = status_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.max_ref   = max_w[0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    status_next    = STATUS_OK;
                    state_next     = ST_IDLE;
                    case (kind_reg)
                        KIND_PUSH:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_POP, KIND_TOP, KIND_PEEK_MAX, KIND_POP_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (kind_reg == KIND_POP)
                            begin
                                result_next = value_w[0];
                                ctrl.op     = CELL_POP;
                                count_next  = count_reg - 1'b1;
                            end
                            else if (kind_reg == KIND_TOP)
                            begin
                                result_next = value_w[0];
                            end
                            else if (kind_reg == KIND_PEEK_MAX)
                            begin
                                result_next = max_w[0];
                            end
                            else
                            begin
                                result_next = max_w[0];
                                ctrl.op     = CELL_FIND;
                                count_next  = count_reg - 1'b1;
                                state_next  = ST_REMOVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                ctrl.op = CELL_REMOVE;
                // When the top entry itself was removed no maximum above it needs repair.
                state_next = take_w[0] ? ST_IDLE : ST_WAVE;
            end
            ST_WAVE:
            begin
                ctrl.op = CELL_RELAX;
                if (settled_w[1])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg       <= kind;
            push_value_reg <= push_value;
        end
        result_reg <= result_next;
        status_reg <= status_next;
    end

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            data_t up_value;
            data_t up_max;
            data_t dn_value;
            data_t dn_max;
            logic  dn_settled;
            logic  found_in;
            logic  own_valid;
            logic  dn_valid;

            assign own_valid = (count_reg > CNT_W'(j));
            assign dn_valid  = (count_reg > CNT_W'(j + 1));

            if (j == 0)
            begin : g_top
                assign up_value = push_value_reg;
                assign up_max   = push_max;
                assign found_in = 1'b0;
            end
            else
            begin : g_mid
                assign up_value = value_w[j-1];
                assign up_max   = max_w[j-1];
                assign found_in = found_w[j-1];
            end

            if (j == DEPTH - 1)
            begin : g_bottom
                assign dn_value   = '0;
                assign dn_max     = '0;
                assign dn_settled = 1'b1;
            end
            else
            begin : g_inner
                assign dn_value   = value_w[j+1];
                assign dn_max     = max_w[j+1];
                assign dn_settled = settled_w[j+1];
            end

            mxs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .own_valid  (own_valid),
                .up_value   (up_value),
                .up_max     (up_max),
                .dn_value   (dn_value),
                .dn_max     (dn_max),
                .dn_valid   (dn_valid),
                .dn_settled (dn_settled),
                .found_in   (found_in),
                .found_out  (found_w[j]),
                .value_q    (value_w[j]),
                .max_q      (max_w[j]),
                .take_q     (take_w[j]),
                .settled_q  (settled_w[j])
            );
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

// File: src/mxs_cell.sv
// One stack cell: holds an entry and the maximum of that entry and all entries below it.
// Uses mxs_pkg. Cell 0 is the top of the stack.
`default_nettype none
module mxs_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mxs_pkg::cell_ctrl_t    ctrl,
    input  wire logic                   own_valid,
    input  wire mxs_pkg::data_t         up_value,
    input  wire mxs_pkg::data_t         up_max,
    input  wire mxs_pkg::data_t         dn_value,
    input  wire mxs_pkg::data_t         dn_max,
    input  wire logic                   dn_valid,
    input  wire logic                   dn_settled,
    input  wire logic                   found_in,
    output logic                        found_out,
    output mxs_pkg::data_t              value_q,
    output mxs_pkg::data_t              max_q,
    output logic                        take_q,
    output logic                        settled_q
);
    import mxs_pkg::*;

    data_t value_reg;
    data_t value_next;
    data_t max_reg;
    data_t max_next;
    logic  take_reg;
    logic  take_next;
    logic  settled_reg;
    logic  settled_next;
    data_t relax_max;

    // The topmost matching cell and every cell below it belong to the shifting part.
    assign found_out = found_in | (own_valid && (value_reg == ctrl.max_ref));

    assign relax_max = (dn_valid && (dn_max > value_reg)) ? dn_max : value_reg;

    always_comb
    begin
        value_next   = value_reg;
        max_next     = max_reg;
        take_next    = take_reg;
        settled_next = settled_reg;
        case (ctrl.op)
            CELL_PUSH:
            begin
                value_next = up_value;
                max_next   = up_max;
            end
            CELL_POP:
            begin
                value_next = dn_value;
                max_next   = dn_max;
            end
            CELL_FIND:
            begin
                take_next = found_out;
            end
            CELL_REMOVE:
            begin
                if (take_reg)
                begin
                    value_next = dn_value;
                    max_next   = dn_max;
                end
                settled_next = take_reg;
            end
            CELL_RELAX:
            begin
                if (!settled_reg)
                begin
                    max_next     = relax_max;
                    settled_next = dn_settled;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        max_reg   <= max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_reg    <= 1'b0;
            settled_reg <= 1'b1;
        end
        else
        begin
            take_reg    <= take_next;
            settled_reg <= settled_next;
        end
    end

    assign value_q   = value_reg;
    assign max_q     = max_reg;
    assign take_q    = take_reg;
    assign settled_q = settled_reg;

endmodule
`default_nettype wire
